// ===== rtl/core/csg_pkg.sv =====
`default_nettype none
package csg_pkg;

	localparam int CoordBits = 16;
	localparam int DivBits   = 6;
	localparam int DivMin    = 2;
	localparam int DivMax    = 62;
	localparam int DivReset  = 20;
	localparam int AddrBits  = 2;
	localparam int DataBits  = 32;

	// register map (byte addresses)
	localparam logic [AddrBits-1:0] RegDivAddr = AddrBits'(0);

	typedef struct packed {
		logic signed [CoordBits-1:0] first_x;
		logic signed [CoordBits-1:0] first_y;
		logic signed [CoordBits-1:0] apex_x;
		logic signed [CoordBits-1:0] apex_y;
		logic signed [CoordBits-1:0] third_x;
		logic signed [CoordBits-1:0] third_y;
	} item_t;

	typedef struct packed {
		logic signed [CoordBits-1:0] start_x;
		logic signed [CoordBits-1:0] start_y;
		logic signed [CoordBits-1:0] end_x;
		logic signed [CoordBits-1:0] end_y;
		logic                        pen_up_move;
		logic                        last_segment;
	} seg_t;

endpackage
`default_nettype wire

// ===== rtl/core/curve_stitch_segment_generator_core.sv =====
`default_nettype none
// Curve-stitch segment generator. Each item beat carries three corners P1, P2, P3; the block
// returns n+1 segment beats: P1-P2, P2-P3, then the stitches i = 1..n-1 from
// P1+(P2-P1)*i/n to P2+(P3-P2)*i/n, each segment turned so that it starts at the end nearer
// the pen. n is the divisions register clamped to 2..62. A bit-serial divider first splits
// each axis step into quotient and remainder; each segment then passes through a pick state
// that forms its ends, a squarer state on the single shared squarer for the two squared pen
// distances, and an emit state that loads the output register and waits while the segment
// side stalls.
// item_ready is high only between items.
module curve_stitch_segment_generator_core
	import csg_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  item_t               item,
	output logic                seg_valid,
	input  logic                seg_ready,
	output seg_t                seg,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [AddrBits-1:0] paddr,
	input  logic [DataBits-1:0] pwdata,
	output logic [DataBits-1:0] prdata,
	output logic                pready
);

	localparam int Lanes   = 4;
	localparam int CntBits = $clog2(CoordBits);
	localparam int SqBits  = 2 * CoordBits;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_DIV  = 5'b00010,
		ST_PICK = 5'b00100,
		ST_SQ   = 5'b01000,
		ST_EMIT = 5'b10000
	} state_t;

	state_t state_q;

	logic [DivBits-1:0] divisions_q;
	logic [DivBits-1:0] n_clamp;
	logic [DivBits-1:0] n_q;
	logic [DivBits-1:0] seg_cnt_q;
	logic [CntBits-1:0] div_cnt_q;
	logic [2:0]         sq_cnt_q;

	// lanes: 0 = A.x, 1 = A.y, 2 = B.x, 3 = B.y
	logic signed [CoordBits-1:0] base_q [Lanes];
	logic                        neg_q  [Lanes];
	logic [CoordBits-1:0]        quo_q  [Lanes];
	logic [DivBits-1:0]          rem_q  [Lanes];
	logic [CoordBits-1:0]        acc_q  [Lanes];
	logic [DivBits-1:0]          frac_q [Lanes];
	logic signed [CoordBits-1:0] third_x_q, third_y_q;

	logic signed [CoordBits-1:0] in_base [Lanes];
	logic signed [CoordBits-1:0] in_tgt  [Lanes];
	logic                        in_neg  [Lanes];
	logic [CoordBits-1:0]        in_mag  [Lanes];
	logic [DivBits-1:0]          rem_nx  [Lanes];
	logic [CoordBits-1:0]        quo_nx  [Lanes];
	logic [DivBits-1:0]          frac_nx [Lanes];
	logic [CoordBits-1:0]        acc_nx  [Lanes];
	logic signed [CoordBits-1:0] pt      [Lanes];

	logic signed [CoordBits-1:0] ax_q, ay_q, bx_q, by_q;
	logic signed [CoordBits-1:0] pen_x_q, pen_y_q;
	logic                        pen_placed_q;

	logic [SqBits-1:0]   prod_s1;
	logic [SqBits:0]     dist_a_q, dist_b_q;
	logic signed [CoordBits-1:0] sq_pt, sq_pen;
	logic signed [CoordBits:0]   sq_diff;
	logic [CoordBits-1:0]        sq_mag;

	logic                        near_a;
	logic signed [CoordBits-1:0] st_x, st_y, en_x, en_y;
	logic                        load_seg;
	logic                        last_seg;
	logic                        cfg_wr;
	seg_t                        seg_q;
	logic                        seg_valid_q;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr == RegDivAddr);
	assign prdata = (paddr == RegDivAddr) ? {{(DataBits-DivBits){1'b0}}, divisions_q} : '0;

	always_comb begin
		if (divisions_q < DivBits'(DivMin)) begin
			n_clamp = DivBits'(DivMin);
		end else if (divisions_q > DivBits'(DivMax)) begin
			n_clamp = DivBits'(DivMax);
		end else begin
			n_clamp = divisions_q;
		end
	end

	// per-lane set-up, divider step, stitch advance and point
	always_comb begin
		logic signed [CoordBits:0] delta;
		logic signed [CoordBits:0] off;
		logic [DivBits:0]          trial;
		logic [DivBits:0]          fsum;
		logic                      ge;
		logic                      wrap;
		in_base[0] = item.first_x;
		in_base[1] = item.first_y;
		in_base[2] = item.apex_x;
		in_base[3] = item.apex_y;
		in_tgt[0]  = item.apex_x;
		in_tgt[1]  = item.apex_y;
		in_tgt[2]  = item.third_x;
		in_tgt[3]  = item.third_y;
		for (int k = 0; k < Lanes; k++) begin
			delta     = {in_tgt[k][CoordBits-1], in_tgt[k]}
			          - {in_base[k][CoordBits-1], in_base[k]};
			in_neg[k] = delta[CoordBits];
			in_mag[k] = delta[CoordBits] ? CoordBits'(-delta) : delta[CoordBits-1:0];

			trial     = {rem_q[k], quo_q[k][CoordBits-1]};
			ge        = trial >= {1'b0, n_q};
			rem_nx[k] = ge ? DivBits'(trial - {1'b0, n_q}) : trial[DivBits-1:0];
			quo_nx[k] = {quo_q[k][CoordBits-2:0], ge};

			fsum       = {1'b0, frac_q[k]} + {1'b0, rem_q[k]};
			wrap       = fsum >= {1'b0, n_q};
			frac_nx[k] = wrap ? DivBits'(fsum - {1'b0, n_q}) : fsum[DivBits-1:0];
			acc_nx[k]  = acc_q[k] + quo_q[k] + CoordBits'(wrap);

			off   = neg_q[k] ? -$signed({1'b0, acc_q[k]}) : $signed({1'b0, acc_q[k]});
			pt[k] = CoordBits'({base_q[k][CoordBits-1], base_q[k]} + off);
		end
	end

	// shared squarer operand: A.x, A.y, B.x, B.y against the pen
	always_comb begin
		case (sq_cnt_q[1:0])
			2'd0: sq_pt = ax_q;
			2'd1: sq_pt = ay_q;
			2'd2: sq_pt = bx_q;
			2'd3: sq_pt = by_q;
			default: sq_pt = ax_q;
		endcase
		sq_pen  = sq_cnt_q[0] ? pen_y_q : pen_x_q;
		sq_diff = {sq_pt[CoordBits-1], sq_pt} - {sq_pen[CoordBits-1], sq_pen};
		sq_mag  = sq_diff[CoordBits] ? CoordBits'(-sq_diff) : sq_diff[CoordBits-1:0];
	end

	// equal distances reverse the segment
	assign near_a   = dist_a_q < dist_b_q;
	assign st_x     = near_a ? ax_q : bx_q;
	assign st_y     = near_a ? ay_q : by_q;
	assign en_x     = near_a ? bx_q : ax_q;
	assign en_y     = near_a ? by_q : ay_q;
	assign last_seg = seg_cnt_q == n_q;
	assign load_seg = (state_q == ST_EMIT) && (!seg_valid_q || seg_ready);

	assign item_ready = state_q == ST_IDLE;
	assign seg_valid  = seg_valid_q;
	assign seg        = seg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			divisions_q  <= DivBits'(DivReset);
			seg_valid_q  <= 1'b0;
			pen_x_q      <= '1;
			pen_y_q      <= '1;
			pen_placed_q <= 1'b0;
			seg_cnt_q    <= '0;
			div_cnt_q    <= '0;
			sq_cnt_q     <= '0;
		end else begin
			if (cfg_wr) begin
				divisions_q <= pwdata[DivBits-1:0];
			end
			if (load_seg) begin
				seg_valid_q <= 1'b1;
			end else if (seg_ready) begin
				seg_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						div_cnt_q <= '0;
						state_q   <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_cnt_q == CntBits'(CoordBits - 1)) begin
						seg_cnt_q <= '0;
						state_q   <= ST_PICK;
					end else begin
						div_cnt_q <= div_cnt_q + 1'b1;
					end
				end
				ST_PICK: begin
					sq_cnt_q <= '0;
					state_q  <= ST_SQ;
				end
				ST_SQ: begin
					if (sq_cnt_q == 3'd4) begin
						state_q <= ST_EMIT;
					end else begin
						sq_cnt_q <= sq_cnt_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (load_seg) begin
						pen_x_q      <= en_x;
						pen_y_q      <= en_y;
						pen_placed_q <= 1'b1;
						if (last_seg) begin
							state_q <= ST_IDLE;
						end else begin
							seg_cnt_q <= seg_cnt_q + 1'b1;
							state_q   <= ST_PICK;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			n_q       <= n_clamp;
			third_x_q <= item.third_x;
			third_y_q <= item.third_y;
			for (int k = 0; k < Lanes; k++) begin
				base_q[k] <= in_base[k];
				neg_q[k]  <= in_neg[k];
				quo_q[k]  <= in_mag[k];
				rem_q[k]  <= '0;
			end
		end
		if (state_q == ST_DIV) begin
			for (int k = 0; k < Lanes; k++) begin
				quo_q[k]  <= quo_nx[k];
				rem_q[k]  <= rem_nx[k];
				acc_q[k]  <= '0;
				frac_q[k] <= '0;
			end
		end
		if (state_q == ST_PICK) begin
			dist_a_q <= '0;
			dist_b_q <= '0;
			case (seg_cnt_q)
				DivBits'(0): begin
					ax_q <= base_q[0];
					ay_q <= base_q[1];
					bx_q <= base_q[2];
					by_q <= base_q[3];
				end
				DivBits'(1): begin
					ax_q <= base_q[2];
					ay_q <= base_q[3];
					bx_q <= third_x_q;
					by_q <= third_y_q;
				end
				default: begin
					ax_q <= pt[0];
					ay_q <= pt[1];
					bx_q <= pt[2];
					by_q <= pt[3];
				end
			endcase
		end
		if (state_q == ST_SQ) begin
			prod_s1 <= sq_mag * sq_mag;
			if (sq_cnt_q == 3'd1 || sq_cnt_q == 3'd2) begin
				dist_a_q <= dist_a_q + {1'b0, prod_s1};
			end else if (sq_cnt_q == 3'd3 || sq_cnt_q == 3'd4) begin
				dist_b_q <= dist_b_q + {1'b0, prod_s1};
			end
		end
		if (load_seg) begin
			seg_q.start_x      <= st_x;
			seg_q.start_y      <= st_y;
			seg_q.end_x        <= en_x;
			seg_q.end_y        <= en_y;
			seg_q.pen_up_move  <= !pen_placed_q || st_x != pen_x_q || st_y != pen_y_q;
			seg_q.last_segment <= last_seg;
			// step the stitch accumulators for the next stitch
			if (!last_seg && seg_cnt_q != '0) begin
				for (int k = 0; k < Lanes; k++) begin
					acc_q[k]  <= acc_nx[k];
					frac_q[k] <= frac_nx[k];
				end
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/csg_port_checker.sv =====
`default_nettype none
module csg_port_checker
	import csg_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                item_valid,
	input logic                item_ready,
	input logic                seg_valid,
	input logic                seg_ready,
	input seg_t                seg,
	input logic                psel,
	input logic                penable,
	input logic                pwrite,
	input logic [AddrBits-1:0] paddr,
	input logic [DataBits-1:0] pwdata,
	input logic [DataBits-1:0] prdata,
	input logic                pready
);

	logic                        seen_q;
	logic signed [CoordBits-1:0] last_x_q, last_y_q;
	logic                        seg_beat;

	assign seg_beat = seg_valid && seg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q   <= 1'b0;
			last_x_q <= '0;
			last_y_q <= '0;
		end else if (seg_beat) begin
			seen_q   <= 1'b1;
			last_x_q <= seg.end_x;
			last_y_q <= seg.end_y;
		end
	end

	// the block is busy once an item is taken
	a_busy_after_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("item_ready stayed high after an item beat");

	// no pen-up move means the stroke continues from the previous end
	a_pen_continuity: assert property (@(posedge clk) disable iff (!arst_n)
		seg_beat && !seg.pen_up_move |->
			seen_q && seg.start_x == last_x_q && seg.start_y == last_y_q)
		else $error("pen_up_move low but start is not the previous end");

	// divisions reads back what was written
	a_div_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && paddr == RegDivAddr |=>
			paddr != RegDivAddr || prdata[DivBits-1:0] == $past(pwdata[DivBits-1:0]))
		else $error("divisions readback mismatch");

	a_seg_hold: assert property (@(posedge clk) disable iff (!arst_n)
		seg_valid && !seg_ready |=> seg_valid && $stable(seg))
		else $error("segment beat dropped or changed while stalled");

endmodule

bind curve_stitch_segment_generator_core csg_port_checker u_csg_port_checker (.*);
`default_nettype wire
